/* rtl/ows_pkg.sv */
`timescale 1ns / 1ps
// ows_pkg: shared constants, types and elaboration-time table functions for
// the overdrive waveshaper/mix block. No dependencies.
package ows_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int EXP_DEPTH_DEF    = 256;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] GAIN_MIN = 16'd256;
  localparam logic [15:0] GAIN_MAX = 16'd51200;
  localparam logic [15:0] MIX_ONE  = 16'd32768;

  typedef enum logic [1:0] {
    REG_DRIVE_GAIN = 2'd0,
    REG_WET_MIX    = 2'd1,
    REG_CLIP_MODE  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CLIP_HARD = 1'b0,
    CLIP_SOFT = 1'b1
  } clip_mode_t;

  // Segment of the hard clipping curve
  typedef enum logic [1:0] {
    HARD_LIN  = 2'd0,
    HARD_KNEE = 2'd1,
    HARD_SAT  = 2'd2
  } hard_seg_t;

  // Effective (range-limited) settings seen by the datapath
  typedef struct packed {
    logic [15:0] drive_gain;
    logic [15:0] wet_mix;
    clip_mode_t  clip_mode;
  } ows_cfg_t;

  // Per-entry ratio of the exp table: truncated Taylor series of exp(-q/2^32)
  function automatic logic [63:0] exp_step(input logic [63:0] q);
    logic [63:0] term;
    logic [63:0] step;
    term = 64'd1 << 32;
    step = 64'd1 << 32;
    term = ((term * q) >> 32) / 1;  step = step - term;
    term = ((term * q) >> 32) / 2;  step = step + term;
    term = ((term * q) >> 32) / 3;  step = step - term;
    term = ((term * q) >> 32) / 4;  step = step + term;
    term = ((term * q) >> 32) / 5;  step = step - term;
    term = ((term * q) >> 32) / 6;  step = step + term;
    term = ((term * q) >> 32) / 7;  step = step - term;
    term = ((term * q) >> 32) / 8;  step = step + term;
    term = ((term * q) >> 32) / 9;  step = step - term;
    term = ((term * q) >> 32) / 10; step = step + term;
    term = ((term * q) >> 32) / 11; step = step - term;
    term = ((term * q) >> 32) / 12; step = step + term;
    return step;
  endfunction

  // Table entry pos in Q.32: repeated rounded multiplication by the step
  function automatic logic [32:0] exp_entry(input logic [63:0] step, input int unsigned pos);
    logic [63:0] val;
    val = 64'd1 << 32;
    for (int unsigned i = 0; i < pos; i++) begin
      val = (val * step + (64'd1 << 31)) >> 32;
    end
    return val[32:0];
  endfunction

endpackage

/* rtl/ows_cfg_regs.sv */
`timescale 1ns / 1ps
// ows_cfg_regs: APB-style register file (drive gain, wet mix, clip mode)
// and range limiting of the settings. Depends on ows_pkg.
module ows_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ows_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ows_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ows_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output ows_pkg::ows_cfg_t               cfg_eff
);
  import ows_pkg::*;

  logic [15:0] drive_gain_r;
  logic [15:0] wet_mix_r;
  clip_mode_t  clip_mode_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_gain_r <= GAIN_MIN;
      wet_mix_r    <= MIX_ONE;
      clip_mode_r  <= CLIP_HARD;
    end else if (wr_en) begin
      unique case (cfg_paddr[CFG_ADDR_W-1:2])
        REG_DRIVE_GAIN: drive_gain_r <= cfg_pwdata[15:0];
        REG_WET_MIX:    wet_mix_r    <= cfg_pwdata[15:0];
        REG_CLIP_MODE:  clip_mode_r  <= clip_mode_t'(cfg_pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[CFG_ADDR_W-1:2])
      REG_DRIVE_GAIN: cfg_prdata = {16'd0, drive_gain_r};
      REG_WET_MIX:    cfg_prdata = {16'd0, wet_mix_r};
      REG_CLIP_MODE:  cfg_prdata = {31'd0, clip_mode_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Clamp gain to 1.0..200.0 and mix to at most 1.0
  always_comb begin
    if (drive_gain_r < GAIN_MIN) begin
      cfg_eff.drive_gain = GAIN_MIN;
    end else if (drive_gain_r > GAIN_MAX) begin
      cfg_eff.drive_gain = GAIN_MAX;
    end else begin
      cfg_eff.drive_gain = drive_gain_r;
    end
    cfg_eff.wet_mix   = (wet_mix_r > MIX_ONE) ? MIX_ONE : wet_mix_r;
    cfg_eff.clip_mode = clip_mode_r;
  end

endmodule

/* rtl/ows_drive.sv */
`timescale 1ns / 1ps
// ows_drive: stages 1-3, magnitude of the dry sample, gain multiply and
// rounding to the driven magnitude. Depends on ows_pkg.
module ows_drive #(
  parameter int SAMPLE_WIDTH = ows_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  ows_pkg::ows_cfg_t              cfg,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           a_valid,
  output logic [SAMPLE_WIDTH+7:0]        a_mag,
  output logic signed [SAMPLE_WIDTH-1:0] a_dry
);
  import ows_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SW + 16;

  logic [3:1]            v_r;
  logic signed [SW-1:0]  dry_r [1:3];
  logic [SW-1:0]         mag1_r;
  logic [SW-1:0]         mag1_nxt;
  logic [PW-1:0]         prod2_r;
  logic [PW-1:0]         prod2_nxt;
  logic [PW-1:0]         rnd3;
  logic [SW+7:0]         a3_r;

  // Negating the most negative code wraps to 2^(SW-1), the right magnitude
  assign mag1_nxt  = sample_in[SW-1] ? $unsigned(-sample_in) : $unsigned(sample_in);
  assign prod2_nxt = PW'(mag1_r) * PW'(cfg.drive_gain);
  assign rnd3      = prod2_r + PW'(128);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dry_r[1] <= sample_in;
      dry_r[2] <= dry_r[1];
      dry_r[3] <= dry_r[2];
      mag1_r   <= mag1_nxt;
      prod2_r  <= prod2_nxt;
      a3_r     <= rnd3[PW-1:8];
    end
  end

  assign a_valid = v_r[3];
  assign a_mag   = a3_r;
  assign a_dry   = dry_r[3];

endmodule

/* rtl/ows_clip.sv */
`timescale 1ns / 1ps
// ows_clip: stages 4-8, hard Schetzen curve and soft exponential curve in
// parallel, with the exp ROM. Depends on ows_pkg.
module ows_clip #(
  parameter int SAMPLE_WIDTH    = ows_pkg::SAMPLE_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = ows_pkg::EXP_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  ows_pkg::ows_cfg_t              cfg,
  input  logic                           a_valid,
  input  logic [SAMPLE_WIDTH+7:0]        a_mag,
  input  logic signed [SAMPLE_WIDTH-1:0] a_dry,
  output logic                           y_valid,
  output logic [SAMPLE_WIDTH-1:0]        y_mag,
  output logic signed [SAMPLE_WIDTH-1:0] y_dry
);
  import ows_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int F    = SW - 1;
  localparam int AW   = SW + 8;
  localparam int TW   = AW + 2;
  localparam int ADRW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PPW  = AW + ADRW;
  localparam int IW   = PPW - (F + 3);
  localparam int QW   = 2 * SW;

  localparam logic [SW-1:0] OneQ     = {1'b1, {F{1'b0}}};
  localparam logic [QW-1:0] KneeBias = QW'(3) << (F - 1);
  localparam logic [63:0]   RecipW   = ((64'd1 << (SW + 1)) + 64'd2) / 64'd3;
  localparam logic [SW-1:0] Recip3   = RecipW[SW-1:0];
  localparam logic [33:0]   SoftBias = 34'd1 << (31 - F);
  localparam logic [63:0]   ExpQ     = (64'd8 << 32) / 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0]   ExpStep  = exp_step(ExpQ);

  logic [32:0] exp_rom [0:EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_exp_rom
    assign exp_rom[gi] = exp_entry(ExpStep, gi);
  end

  logic [8:4]           v_r;
  logic signed [SW-1:0] dry_r [4:8];

  // hard path
  logic [TW-1:0]  three_a;
  hard_seg_t      seg4_nxt;
  logic [SW-1:0]  hval4_nxt;
  hard_seg_t      seg4_r, seg5_r, seg6_r, seg7_r;
  logic [SW-1:0]  hval4_r, hval5_r, hval6_r, hval7_r;
  logic [QW-1:0]  tt5_r;
  logic [QW-1:0]  nsum6;
  logic [SW-1:0]  n6_r;
  logic [QW-1:0]  q7_r;
  logic [SW-1:0]  hy8;

  // soft path
  logic [PPW-1:0]  p4;
  logic [IW-1:0]   idx4;
  logic            ssat4_nxt;
  logic            ssat4_r, ssat5_r, ssat6_r, ssat7_r;
  logic [ADRW-1:0] sadr4_r;
  logic [15:0]     sf4_r, sf5_r, sf6_r;
  logic [32:0]     e0_5_r, e1_5_r, e0_6_r, e0_7_r;
  logic [31:0]     d6_r;
  logic [47:0]     dp7_r;
  logic [32:0]     e8;
  logic [33:0]     esum8;
  logic [SW-1:0]   sy8;
  logic [SW-1:0]   y8_r;

  assign three_a = TW'(a_mag) + TW'({a_mag, 1'b0});

  always_comb begin
    priority if (three_a < TW'(OneQ)) begin
      seg4_nxt  = HARD_LIN;
      hval4_nxt = SW'({a_mag, 1'b0});
    end else if (three_a > TW'({OneQ, 1'b0})) begin
      seg4_nxt  = HARD_SAT;
      hval4_nxt = OneQ;
    end else begin
      seg4_nxt  = HARD_KNEE;
      hval4_nxt = SW'(TW'({OneQ, 1'b0}) - three_a);
    end
  end

  assign p4        = PPW'(a_mag) * PPW'(EXP_TABLE_DEPTH);
  assign idx4      = p4[PPW-1:F+3];
  assign ssat4_nxt = (idx4 >= IW'(EXP_TABLE_DEPTH));

  assign nsum6 = tt5_r + KneeBias;

  // soft: interpolate between neighbors, round to Q.F
  assign e8    = e0_7_r - 33'(dp7_r >> 16);
  assign esum8 = 34'(e8) + SoftBias;
  assign sy8   = OneQ - SW'(esum8 >> (32 - F));

  always_comb begin
    unique case (seg7_r)
      HARD_LIN:  hy8 = hval7_r;
      HARD_KNEE: hy8 = OneQ - SW'(q7_r >> (SW + 1));
      HARD_SAT:  hy8 = OneQ;
      default:   hy8 = OneQ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:4], a_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dry_r[4] <= a_dry;
      for (int s = 5; s <= 8; s++) begin
        dry_r[s] <= dry_r[s-1];
      end
      // stage 4
      seg4_r  <= seg4_nxt;
      hval4_r <= hval4_nxt;
      ssat4_r <= ssat4_nxt;
      sadr4_r <= ssat4_nxt ? '0 : idx4[ADRW-1:0];
      sf4_r   <= p4[F+2:F-13];
      // stage 5
      seg5_r  <= seg4_r;
      hval5_r <= hval4_r;
      tt5_r   <= QW'(hval4_r) * QW'(hval4_r);
      ssat5_r <= ssat4_r;
      sf5_r   <= sf4_r;
      e0_5_r  <= exp_rom[sadr4_r];
      e1_5_r  <= exp_rom[sadr4_r + ADRW'(1)];
      // stage 6
      seg6_r  <= seg5_r;
      hval6_r <= hval5_r;
      n6_r    <= nsum6[QW-2:F];
      ssat6_r <= ssat5_r;
      sf6_r   <= sf5_r;
      d6_r    <= 32'(e0_5_r - e1_5_r);
      e0_6_r  <= e0_5_r;
      // stage 7: divide by three through the reciprocal
      seg7_r  <= seg6_r;
      hval7_r <= hval6_r;
      q7_r    <= QW'(n6_r) * QW'(Recip3);
      ssat7_r <= ssat6_r;
      e0_7_r  <= e0_6_r;
      dp7_r   <= 48'(d6_r) * 48'(sf6_r);
      // stage 8
      if (cfg.clip_mode == CLIP_SOFT) begin
        y8_r <= ssat7_r ? OneQ : sy8;
      end else begin
        y8_r <= hy8;
      end
    end
  end

  assign y_valid = v_r[8];
  assign y_mag   = y8_r;
  assign y_dry   = dry_r[8];

endmodule

/* rtl/ows_mix.sv */
`timescale 1ns / 1ps
// ows_mix: stages 9-10, dry/wet products, sum with rounding, and output
// saturation. Depends on ows_pkg.
module ows_mix #(
  parameter int SAMPLE_WIDTH = ows_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  ows_pkg::ows_cfg_t              cfg,
  input  logic                           y_valid,
  input  logic [SAMPLE_WIDTH-1:0]        y_mag,
  input  logic signed [SAMPLE_WIDTH-1:0] y_dry,
  output logic                           res_valid,
  output logic signed [SAMPLE_WIDTH-1:0] res_sample
);
  import ows_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int F     = SW - 1;
  localparam int WPW   = SW + 16;
  localparam int DPW   = SW + 17;
  localparam int ACC_W = SW + 18;
  localparam int MixRound = 16384;

  localparam logic signed [SW-1:0] MaxS = {1'b0, {F{1'b1}}};
  localparam logic signed [SW-1:0] MinS = {1'b1, {F{1'b0}}};

  logic [10:9]              v_r;
  logic [15:0]              dmix;
  logic [WPW-1:0]           pw9_r;
  logic signed [DPW-1:0]    pd9_r;
  logic signed [DPW-1:0]    pd9_nxt;
  logic                     neg9_r;
  logic signed [ACC_W-1:0]  pw_ext;
  logic signed [ACC_W-1:0]  pd_ext;
  logic signed [ACC_W-1:0]  acc10_nxt;
  logic signed [ACC_W-1:0]  acc10_r;
  logic signed [ACC_W-1:0]  sh;

  assign dmix    = MIX_ONE - cfg.wet_mix;
  assign pd9_nxt = DPW'($signed({1'b0, dmix})) * DPW'(y_dry);

  // Wet product is unsigned; apply the dry sample's sign here
  assign pw_ext    = $signed(ACC_W'(pw9_r));
  assign pd_ext    = ACC_W'(pd9_r);
  assign acc10_nxt = (neg9_r ? -pw_ext : pw_ext) + pd_ext + ACC_W'(MixRound);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[9], y_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw9_r   <= WPW'(cfg.wet_mix) * WPW'(y_mag);
      pd9_r   <= pd9_nxt;
      neg9_r  <= y_dry[SW-1];
      acc10_r <= acc10_nxt;
    end
  end

  assign sh = acc10_r >>> 15;

  always_comb begin
    if (sh[ACC_W-1:F] == '0 || sh[ACC_W-1:F] == '1) begin
      res_sample = sh[SW-1:0];
    end else begin
      res_sample = sh[ACC_W-1] ? MinS : MaxS;
    end
  end

  assign res_valid = v_r[10];

endmodule

/* rtl/overdrive_waveshaper_mix_top.sv */
`timescale 1ns / 1ps
// overdrive_waveshaper_mix_top: drive, hard/soft clip and dry/wet mix of a
// signed Q1.F audio stream. Depends on ows_pkg, ows_cfg_regs, ows_drive,
// ows_clip and ows_mix.
//
// Input channel (in_valid/in_stall/in_sample_in) takes one sample per
// transfer; the result channel (out_valid/out_stall/out_sample_out) returns
// exactly one sample per input, in order. Settings are written through the
// cfg_ APB port: drive gain at 0x0, wet mix at 0x4, clip mode at 0x8; write
// them only while the stream is drained.
// Throughput: one sample per cycle while the skid buffer is empty, set
// by the ten-stage pipeline (three drive stages, five clip stages, two mix
// stages) that advances as a whole and feeds the output register.
// The output register is backed by a one-entry skid buffer, so in_stall is
// a register: it rises only when the receiver stalls with a result waiting
// and another result arrives; the pipeline then holds until the skid drains.
// Reset (synchronous, rst_n low) empties the pipeline and the output buffer
// and loads the default settings. The exp table is an elaborated ROM, so no
// clearing pass follows reset.
module overdrive_waveshaper_mix_top #(
  parameter int SAMPLE_WIDTH    = ows_pkg::SAMPLE_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = ows_pkg::EXP_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample_in,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]  out_sample_out,
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ows_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ows_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ows_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import ows_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  ows_cfg_t             cfg_eff;
  logic                 en;
  logic                 a_valid;
  logic [SW+7:0]        a_mag;
  logic signed [SW-1:0] a_dry;
  logic                 y_valid;
  logic [SW-1:0]        y_mag;
  logic signed [SW-1:0] y_dry;
  logic                 res_valid;
  logic signed [SW-1:0] res_sample;

  // output register and skid buffer
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_data_r, out_data_nxt;
  logic                 skid_full_r, skid_full_nxt;
  logic signed [SW-1:0] skid_data_r, skid_data_nxt;
  logic                 take;

  ows_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_eff     (cfg_eff)
  );

  ows_drive #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_drive (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_eff),
    .in_valid  (in_valid),
    .sample_in (in_sample_in),
    .a_valid   (a_valid),
    .a_mag     (a_mag),
    .a_dry     (a_dry)
  );

  ows_clip #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_clip (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_eff),
    .a_valid (a_valid),
    .a_mag   (a_mag),
    .a_dry   (a_dry),
    .y_valid (y_valid),
    .y_mag   (y_mag),
    .y_dry   (y_dry)
  );

  ows_mix #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg_eff),
    .y_valid    (y_valid),
    .y_mag      (y_mag),
    .y_dry      (y_dry),
    .res_valid  (res_valid),
    .res_sample (res_sample)
  );

  // Advance the whole pipeline unless the skid buffer holds a result
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;
  assign take     = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skid_full_nxt = skid_full_r;
    skid_data_nxt = skid_data_r;
    if (skid_full_r) begin
      // pipeline is frozen; drain the skid into the output on a transfer
      if (take) begin
        out_data_nxt  = skid_data_r;
        skid_full_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_sample;
      end else begin
        // receiver is stalled: park the new result
        skid_full_nxt = 1'b1;
        skid_data_nxt = res_sample;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  // A parked result always has one in front of it
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid buffer full while output register empty");

  // A parked result holds while the receiver keeps stalling
  a_skid_holds : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r && out_stall |=> skid_full_r && $stable(skid_data_r))
    else $error("parked result lost or changed under stall");

  // A result reaching a stalled, occupied output must be parked, not dropped
  a_park_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && !skid_full_r && res_valid |=> skid_full_r)
    else $error("result dropped while receiver stalled");

  // A finished result with a free buffer leaves the output valid next cycle
  a_result_presented : assert property (@(posedge clk) disable iff (!rst_n)
    !skid_full_r && res_valid |=> out_valid_r)
    else $error("finished result not presented");

endmodule
